// ===== rtl/core/utf8_stream_decoder_defines.svh =====
// Assertion macros shared by the UTF-8 stream decoder modules.
`ifndef UTF8_STREAM_DECODER_DEFINES_SVH
`define UTF8_STREAM_DECODER_DEFINES_SVH

// Checks in the same cycle; the module must have clk and arst_n in scope.
`define UDEC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks in the cycle after the antecedent.
`define UDEC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/udec_pkg.sv =====
// Types, constants and helper functions shared by the UTF-8 stream decoder.
`default_nettype none
package udec_pkg;

	localparam int BYTE_W    = 8;
	localparam int CODE_W    = 21;
	localparam int OUT_DW    = 24;
	localparam int MAX_RES   = 4;
	localparam int RES_IW    = $clog2(MAX_RES);
	localparam int HELD_N    = 3;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic [CODE_W-1:0] CODE_MAX   = 21'h10FFFF;
	localparam logic [CODE_W-1:0] SURR_LO    = 21'h00D800;
	localparam logic [CODE_W-1:0] SURR_HI    = 21'h00DFFF;

	typedef enum logic [2:0] {
		CLS_CONT  = 3'd0,
		CLS_ONE   = 3'd1,
		CLS_LEAD2 = 3'd2,
		CLS_LEAD3 = 3'd3,
		CLS_LEAD4 = 3'd4,
		CLS_BAD   = 3'd5
	} cls_t;

	// One input byte's worth of results, handed from the front to the back.
	typedef struct packed {
		logic [MAX_RES-1:0][CODE_W-1:0] code;
		logic [MAX_RES-1:0]             inv;
		logic [RES_IW-1:0]              last;
	} job_t;

	function automatic cls_t class_of(input logic [BYTE_W-1:0] b);
		cls_t c;
		if (b < 8'h80) begin
			c = CLS_ONE;
		end else if (b[7:6] == 2'b10) begin
			c = CLS_CONT;
		end else if (b < 8'hC2) begin
			c = CLS_BAD;
		end else if (b < 8'hE0) begin
			c = CLS_LEAD2;
		end else if (b < 8'hF0) begin
			c = CLS_LEAD3;
		end else if (b < 8'hF5) begin
			c = CLS_LEAD4;
		end else begin
			c = CLS_BAD;
		end
		return c;
	endfunction

	// Payload bits of a lead byte for a sequence of the given length.
	function automatic logic [BYTE_W-1:0] lead_mask(input cls_t c);
		logic [BYTE_W-1:0] m;
		unique case (c)
			CLS_LEAD2: m = 8'h1F;
			CLS_LEAD3: m = 8'h0F;
			CLS_LEAD4: m = 8'h07;
			default:   m = 8'h00;
		endcase
		return m;
	endfunction

	// Smallest code point that a sequence of the given length may carry.
	function automatic logic [CODE_W-1:0] min_code(input logic [2:0] len);
		logic [CODE_W-1:0] m;
		unique case (len)
			3'd2:    m = 21'h000080;
			3'd3:    m = 21'h000800;
			3'd4:    m = 21'h010000;
			default: m = '0;
		endcase
		return m;
	endfunction

	function automatic logic ill_formed(input logic [CODE_W-1:0] u, input logic [2:0] len);
		return (u < min_code(len)) || (u > CODE_MAX) || ((u >= SURR_LO) && (u <= SURR_HI));
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/udec_front.sv =====
// Front part: accepts bytes, tracks the open sequence and builds result jobs.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module udec_front
	import udec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [BYTE_W-1:0] s_tdata,
	input  wire logic              s_tlast,
	input  wire logic              full,
	output      logic              push,
	output      job_t              job
);

	logic [BYTE_W-1:0] lead_q;
	logic [BYTE_W-1:0] held_q [HELD_N];
	logic [CODE_W-1:0] accum_q;
	logic [2:0]        len_q;
	logic [1:0]        hcnt_q;

	logic              accept;
	cls_t              cls;
	logic [CODE_W-1:0] byte_code;
	logic [CODE_W-1:0] acc_new;
	logic              done;
	logic              ill;
	logic              fresh_v;
	logic              fresh_inv;
	logic              fresh_open;
	logic              flush;
	logic              tail_v;
	logic [CODE_W-1:0] tail_code;
	logic              tail_inv;
	logic              open_seq;
	logic              close_seq;
	logic              held_wr;
	logic [2:0]        tail_pos;
	logic [2:0]        count;

	assign s_tready  = !full;
	assign accept    = s_tvalid && s_tready;
	assign cls       = class_of(s_tdata);
	assign byte_code = {{(CODE_W-BYTE_W){1'b0}}, s_tdata};
	assign acc_new   = {accum_q[CODE_W-7:0], s_tdata[5:0]};
	assign done      = ({1'b0, hcnt_q} + 3'd2) >= len_q;
	assign ill       = ill_formed(acc_new, len_q);

	always_comb begin
		fresh_v    = 1'b0;
		fresh_inv  = 1'b0;
		fresh_open = 1'b0;
		if (cls == CLS_ONE) begin
			fresh_v = 1'b1;
		end else if (cls == CLS_CONT || cls == CLS_BAD || s_tlast) begin
			fresh_v   = 1'b1;
			fresh_inv = 1'b1;
		end else begin
			fresh_open = 1'b1;
		end
	end

	always_comb begin
		flush     = 1'b0;
		tail_v    = 1'b0;
		tail_code = byte_code;
		tail_inv  = 1'b0;
		open_seq  = 1'b0;
		close_seq = 1'b0;
		held_wr   = 1'b0;
		if (len_q == 3'd0) begin
			tail_v   = fresh_v;
			tail_inv = fresh_inv;
			open_seq = fresh_open;
		end else if (cls == CLS_CONT) begin
			held_wr = 1'b1;
			if (done && !ill) begin
				tail_v    = 1'b1;
				tail_code = acc_new;
				close_seq = 1'b1;
			end else if (done || s_tlast) begin
				flush     = 1'b1;
				tail_v    = 1'b1;
				tail_inv  = 1'b1;
				close_seq = 1'b1;
			end
		end else begin
			flush     = 1'b1;
			tail_v    = fresh_v;
			tail_inv  = fresh_inv;
			open_seq  = fresh_open;
			close_seq = !fresh_open;
		end
	end

	always_comb begin
		tail_pos = flush ? ({1'b0, hcnt_q} + 3'd1) : 3'd0;
		count    = tail_pos + {2'b0, tail_v};
		job      = '0;
		job.last = RES_IW'(count - 3'd1);
		if (flush) begin
			job.code[0] = {{(CODE_W-BYTE_W){1'b0}}, lead_q};
			job.inv[0]  = 1'b1;
		end
		for (int k = 1; k < MAX_RES; k++) begin
			if (flush && (k <= int'(hcnt_q))) begin
				job.code[k] = {{(CODE_W-BYTE_W){1'b0}}, held_q[k-1]};
				job.inv[k]  = 1'b1;
			end
		end
		for (int k = 0; k < MAX_RES; k++) begin
			if (tail_v && (3'(k) == tail_pos)) begin
				job.code[k] = tail_code;
				job.inv[k]  = tail_inv;
			end
		end
		push = accept && (count != 3'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q  <= '0;
			accum_q <= '0;
			len_q   <= '0;
			hcnt_q  <= '0;
		end else if (accept) begin
			if (open_seq) begin
				lead_q  <= s_tdata;
				len_q   <= 3'(cls);
				hcnt_q  <= '0;
				accum_q <= {{(CODE_W-BYTE_W){1'b0}}, s_tdata & lead_mask(cls)};
			end else if (close_seq) begin
				lead_q  <= '0;
				len_q   <= '0;
				hcnt_q  <= '0;
				accum_q <= '0;
			end else if (held_wr) begin
				hcnt_q  <= hcnt_q + 2'd1;
				accum_q <= acc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && held_wr && (hcnt_q < 2'(HELD_N))) begin
			held_q[hcnt_q] <= s_tdata;
		end
	end

	`UDEC_ASSERT_NOW(a_idle_no_held, len_q == 3'd0, hcnt_q == 2'd0, "held bytes without open sequence")
	`UDEC_ASSERT_NOW(a_held_bound, len_q != 3'd0, ({1'b0, hcnt_q} + 3'd2) <= len_q, "held count overrun")

endmodule
`default_nettype wire

// ===== rtl/core/udec_queue.sv =====
// Short job queue between the front and back parts.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module udec_queue
	import udec_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t wr_job,
	input  wire logic pop,
	output      job_t head,
	output      logic full,
	output      logic empty
);

	job_t           mem_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QAW:0]   cnt_q;

	assign full  = cnt_q == (QAW+1)'(QDEPTH);
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`UDEC_ASSERT_NOW(a_no_push_full, push, !full, "push into full queue")
	`UDEC_ASSERT_NOW(a_no_pop_empty, pop, !empty, "pop from empty queue")

endmodule
`default_nettype wire

// ===== rtl/core/udec_back.sv =====
// Back part: walks the head job and presents one result per cycle while not stalled.
`default_nettype none
`include "utf8_stream_decoder_defines.svh"
module udec_back
	import udec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire job_t              head,
	input  wire logic              empty,
	output      logic              pop,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [OUT_DW-1:0] m_tdata,
	output      logic              m_tuser,
	output      logic              m_tlast
);

	logic [RES_IW-1:0] idx_q;
	logic              load;
	logic              at_last;

	assign load    = !empty && (!m_tvalid || m_tready);
	assign at_last = idx_q == head.last;
	assign pop     = load && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			idx_q    <= '0;
		end else begin
			if (load) begin
				m_tvalid <= 1'b1;
				idx_q    <= at_last ? '0 : idx_q + 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			m_tdata <= {{(OUT_DW-CODE_W){1'b0}}, head.code[idx_q]};
			m_tuser <= head.inv[idx_q];
			m_tlast <= at_last;
		end
	end

	`UDEC_ASSERT_NOW(a_idx_idle, empty, idx_q == '0, "result index left open without a job")

endmodule
`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder: front, job queue and back.
//
// Channel  Dir  tdata                        tuser         tlast
// s_*      in   [7:0] in_byte                -             end_of_stream
// m_*      out  [20:0] code_value, pad to 24 is_invalid    last_of_run
//
// The front takes one byte per cycle while the four-entry job queue has room.
// The back presents one result per cycle from the job at the queue head while
// the output is not stalled; a byte gives n results, where n is 0 to 4.
// Throughput is one byte per cycle while bytes average at most one result.
// arst_n clears the sequence state, the queue and the output register.
// An output stall fills the queue, after which s_tready drops.
`default_nettype none
module utf8_stream_decoder
	import udec_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output      logic              s_tready,
	input  wire logic [BYTE_W-1:0] s_tdata,  // [7:0] in_byte
	input  wire logic              s_tlast,
	output      logic              m_tvalid,
	input  wire logic              m_tready,
	output      logic [OUT_DW-1:0] m_tdata,  // [20:0] code_value, [23:21] zero
	output      logic              m_tuser,  // [0] is_invalid
	output      logic              m_tlast
);

	job_t fr_job;
	job_t head;
	logic push;
	logic pop;
	logic full;
	logic empty;

	udec_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.full     (full),
		.push     (push),
		.job      (fr_job)
	);

	udec_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_job (fr_job),
		.pop    (pop),
		.head   (head),
		.full   (full),
		.empty  (empty)
	);

	udec_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== test/tb_utf8_stream_decoder.sv =====
// Self-checking testbench for utf8_stream_decoder: byte requests in, checked code points out.
`default_nettype none
module tb_utf8_stream_decoder;
	import udec_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES = 500;
	localparam int QUIET_LIMIT  = 2000;
	localparam int TAIL_CYCLES  = 32;

	typedef struct {
		logic [BYTE_W-1:0] value;
		logic              eos;
		logic              drain;
	} byte_req_t;

	typedef struct {
		logic [CODE_W-1:0] code;
		logic              inv;
		logic              last;
	} decoded_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_tvalid = 1'b0;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata = '0;
	logic              s_tlast = 1'b0;
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [OUT_DW-1:0] m_tdata;
	logic              m_tuser;
	logic              m_tlast;

	byte_req_t byte_q[$];
	decoded_t  decoded_q[$];
	decoded_t  step_results[$];

	logic              byte_taken = 1'b0;
	int                bytes_accepted = 0;
	int                total_bytes = 0;
	int                quiet_cycles = 0;
	int                mismatches = 0;

	logic [BYTE_W-1:0] seq_lead = '0;
	logic [BYTE_W-1:0] seq_held [0:HELD_N-1] = '{default: '0};
	logic [CODE_W-1:0] seq_accum = '0;
	logic [2:0]        seq_len = '0;
	logic [1:0]        seq_count = '0;

	utf8_stream_decoder dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] in_byte
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [20:0] code_value, [23:21] zero
		.m_tuser  (m_tuser),   // [0] is_invalid
		.m_tlast  (m_tlast)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	function automatic cls_t byte_class(input logic [BYTE_W-1:0] b);
		if (b < 8'h80) return CLS_ONE;
		if (b[7:6] == 2'b10) return CLS_CONT;
		if (b < 8'hC2) return CLS_BAD;
		if (b < 8'hE0) return CLS_LEAD2;
		if (b < 8'hF0) return CLS_LEAD3;
		if (b < 8'hF5) return CLS_LEAD4;
		return CLS_BAD;
	endfunction

	task automatic emit_result(input logic [CODE_W-1:0] code, input logic inv);
		decoded_t r;
		r.code = code;
		r.inv  = inv;
		r.last = 1'b0;
		step_results.push_back(r);
	endtask

	task automatic clear_sequence();
		seq_len   = '0;
		seq_count = '0;
		seq_lead  = '0;
		seq_accum = '0;
	endtask

	task automatic flush_sequence();
		emit_result(CODE_W'(seq_lead), 1'b1);
		for (int k = 0; k < int'(seq_count); k++) begin
			emit_result(CODE_W'(seq_held[k]), 1'b1);
		end
		clear_sequence();
	endtask

	task automatic start_fresh(input logic [BYTE_W-1:0] b, input logic eos);
		cls_t c;
		c = byte_class(b);
		if (c == CLS_ONE) begin
			emit_result(CODE_W'(b), 1'b0);
		end else if (c == CLS_CONT || c == CLS_BAD || eos) begin
			emit_result(CODE_W'(b), 1'b1);
		end else begin
			seq_lead  = b;
			seq_len   = 3'(c);
			seq_count = '0;
			seq_accum = CODE_W'(b & ((8'h80 >> int'(c)) - 8'd1));
		end
	endtask

	task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic eos);
		logic [CODE_W-1:0] least;
		logic              bad;
		step_results.delete();
		if (seq_len == 0) begin
			start_fresh(b, eos);
		end else if (byte_class(b) == CLS_CONT) begin
			if (seq_count < HELD_N) seq_held[seq_count] = b;
			seq_count = seq_count + 2'd1;
			seq_accum = (seq_accum << 6) | CODE_W'(b[5:0]);
			if (int'(seq_count) + 1 >= int'(seq_len)) begin
				case (seq_len)
					3'd2:    least = 21'h000080;
					3'd3:    least = 21'h000800;
					default: least = 21'h010000;
				endcase
				bad = (seq_accum < least) || (seq_accum > CODE_MAX) ||
					((seq_accum >= SURR_LO) && (seq_accum <= SURR_HI));
				if (bad) begin
					flush_sequence();
				end else begin
					emit_result(seq_accum, 1'b0);
					clear_sequence();
				end
			end else if (eos) begin
				flush_sequence();
			end
		end else begin
			flush_sequence();
			start_fresh(b, eos);
		end
		if (step_results.size() != 0) step_results[$].last = 1'b1;
		foreach (step_results[i]) decoded_q.push_back(step_results[i]);
	endtask

	task automatic push_byte(input logic [BYTE_W-1:0] value, input logic eos);
		byte_req_t r;
		r.value = value;
		r.eos   = eos;
		r.drain = 1'b0;
		byte_q.push_back(r);
	endtask

	function automatic logic rand_eos();
		return $urandom_range(0, 19) == 0;
	endfunction

	task automatic push_code_point(input logic [CODE_W-1:0] c);
		if (c < 21'h80) begin
			push_byte(c[7:0], rand_eos());
		end else if (c < 21'h800) begin
			push_byte({3'b110, c[10:6]}, rand_eos());
			push_byte({2'b10, c[5:0]}, rand_eos());
		end else if (c < 21'h10000) begin
			push_byte({4'b1110, c[15:12]}, rand_eos());
			push_byte({2'b10, c[11:6]}, rand_eos());
			push_byte({2'b10, c[5:0]}, rand_eos());
		end else begin
			push_byte({5'b11110, c[20:18]}, rand_eos());
			push_byte({2'b10, c[17:12]}, rand_eos());
			push_byte({2'b10, c[11:6]}, rand_eos());
			push_byte({2'b10, c[5:0]}, rand_eos());
		end
	endtask

	always @(negedge clk) begin : drive_bytes
		byte_req_t nxt;
		logic      send;
		int        phase;
		int        send_idle;
		int        recv_idle;
		if (bytes_accepted < total_bytes / 3) begin
			phase = 0;
		end else if (bytes_accepted < (2 * total_bytes) / 3) begin
			phase = 1;
		end else begin
			phase = 2;
		end
		case (phase)
			0:       begin send_idle = 9;  recv_idle = 69; end
			1:       begin send_idle = 69; recv_idle = 9;  end
			default: begin send_idle = 0;  recv_idle = 0;  end
		endcase
		if (arst_n && (!s_tvalid || byte_taken)) begin
			send = 1'b0;
			if (byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
				if (!byte_q[0].drain || decoded_q.size() == 0) send = 1'b1;
			end
			if (send) begin
				nxt = byte_q.pop_front();
				s_tdata <= nxt.value;
				s_tlast <= nxt.eos;
			end
			s_tvalid <= send;
		end
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_idle);
	end

	always @(posedge clk) begin : check_results
		decoded_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				decode_byte(s_tdata, s_tlast);
				bytes_accepted++;
			end
			if (m_tvalid && m_tready) begin
				if (decoded_q.size() == 0) begin
					report_mismatch($sformatf("result %0h with nothing expected",
						m_tdata[CODE_W-1:0]));
				end else begin
					want = decoded_q.pop_front();
					if (m_tdata[CODE_W-1:0] !== want.code)
						report_mismatch($sformatf("code_value %0h, expected %0h",
							m_tdata[CODE_W-1:0], want.code));
					if (m_tdata[OUT_DW-1:CODE_W] !== '0)
						report_mismatch($sformatf("padding bits %0b not zero",
							m_tdata[OUT_DW-1:CODE_W]));
					if (m_tuser !== want.inv)
						report_mismatch($sformatf("is_invalid %0b, expected %0b for %0h",
							m_tuser, want.inv, want.code));
					if (m_tlast !== want.last)
						report_mismatch($sformatf("last_of_run %0b, expected %0b for %0h",
							m_tlast, want.last, want.code));
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		byte_taken <= arst_n && s_tvalid && s_tready;
	end

	initial begin
		int                kind;
		int                len;
		int                conts;
		logic [BYTE_W-1:0] lead;
		logic [CODE_W-1:0] cp;

		push_byte(8'h00, 1'b0);
		push_byte(8'h7F, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hC0, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'hDF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hED, 1'b0);
		push_byte(8'hA0, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF4, 1'b0);
		push_byte(8'h8F, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hBF, 1'b0);
		push_byte(8'hF4, 1'b0);
		push_byte(8'h90, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hE0, 1'b0);
		push_byte(8'h41, 1'b0);
		push_byte(8'hC2, 1'b1);
		push_byte(8'hE1, 1'b0);
		push_byte(8'h80, 1'b1);
		push_byte(8'hE1, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'hF0, 1'b1);
		byte_q[$].drain = 1'b1;

		total_bytes = byte_q.size() + RANDOM_BYTES;
		while (byte_q.size() < total_bytes) begin
			kind = $urandom_range(0, 99);
			if (kind < 50) begin
				len = $urandom_range(1, 4);
				case (len)
					1:       cp = CODE_W'($urandom_range(0, 'h7F));
					2:       cp = CODE_W'($urandom_range('h80, 'h7FF));
					3:       cp = CODE_W'($urandom_range('h800, 'hFFFF));
					default: cp = CODE_W'($urandom_range('h10000, 'h10FFFF));
				endcase
				push_code_point(cp);
			end else if (kind < 80) begin
				if ($urandom_range(0, 1) == 0) begin
					case ($urandom_range(0, 3))
						0:       lead = 8'hE0;
						1:       lead = 8'hED;
						2:       lead = 8'hF0;
						default: lead = 8'hF4;
					endcase
				end else begin
					lead = BYTE_W'($urandom_range('hC2, 'hF4));
				end
				conts = int'(byte_class(lead)) - 1;
				if (kind >= 65) conts = $urandom_range(0, conts - 1);
				push_byte(lead, rand_eos());
				repeat (conts) push_byte(8'h80 | BYTE_W'($urandom_range(0, 63)), rand_eos());
			end else begin
				push_byte(BYTE_W'($urandom_range(0, 255)), rand_eos());
			end
			if (byte_q.size() == 27 || $urandom_range(0, 99) == 0) byte_q[$].drain = 1'b1;
		end
		total_bytes = byte_q.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while ((byte_q.size() != 0 || s_tvalid || decoded_q.size() != 0) &&
			quiet_cycles < QUIET_LIMIT) begin
			@(negedge clk);
		end

		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("utf8_stream_decoder verification failed");
		end else begin
			repeat (TAIL_CYCLES) @(negedge clk);
			if (decoded_q.size() != 0)
				report_mismatch($sformatf("%0d results never arrived", decoded_q.size()));
			if (mismatches == 0) begin
				$display("utf8_stream_decoder verification clean");
			end else begin
				$display("utf8_stream_decoder verification failed");
			end
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/udec_pkg.sv
rtl/core/udec_front.sv
rtl/core/udec_queue.sv
rtl/core/udec_back.sv
rtl/core/utf8_stream_decoder.sv
test/tb_utf8_stream_decoder.sv
